[design/bts_pkg.sv]
// shared types, constants and helpers for the block transfer sequencer
package bts_pkg;

    // register bank size; list bits and base numbers at or above it are not valid
    localparam int REG_COUNT = 16;
    localparam logic [15:0] LIST_MASK = 16'((33'h1 << REG_COUNT) - 33'h1);

    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [3:0]  PC_INDEX   = 4'd15;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // instruction bit positions
    localparam int BIT_P = 24;
    localparam int BIT_U = 23;
    localparam int BIT_W = 21;
    localparam int BIT_L = 20;

    typedef enum logic [1:0] {
        KIND_XFER  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_UNDEF = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] base_value;
    } instr_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  reg_index;
        logic [31:0] address;
        logic        is_load;
        logic        write_back;
        logic        last;
    } result_t;

    // decoded command handed from front to back
    typedef struct packed {
        logic        undef;
        logic [3:0]  base_reg;
        logic [15:0] reg_list;
        logic [31:0] start_addr;
        logic [31:0] new_base;
        logic        is_load;
        logic        write_back;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // set bits per nibble value
    localparam logic [2:0] NIBBLE_ONES [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    // number of registers in a list, as a small adder tree
    function automatic logic [4:0] list_count(input logic [15:0] list);
        logic [3:0] lo_sum;
        logic [3:0] hi_sum;
        lo_sum = 4'(NIBBLE_ONES[list[3:0]]) + 4'(NIBBLE_ONES[list[7:4]]);
        hi_sum = 4'(NIBBLE_ONES[list[11:8]]) + 4'(NIBBLE_ONES[list[15:12]]);
        return 5'(lo_sum) + 5'(hi_sum);
    endfunction

endpackage

[design/bts_front.sv]
// front end: accepts instructions and decodes them into queued commands
module bts_front (
    input  logic               instr_valid,
    output logic               instr_ready,
    input  bts_pkg::instr_t    instr,
    input  bts_pkg::q_status_t q_status,
    output logic               push,
    output bts_pkg::cmd_t      cmd
);

    logic [31:0] base;
    logic [3:0]  rn;
    logic        p_bit;
    logic        u_bit;
    logic        w_bit;
    logic [15:0] list;
    logic [4:0]  count;
    logic [31:0] span;
    logic [31:0] up_start;
    logic [31:0] down_start;
    logic [31:0] new_base;

    // accept whenever the queue has room
    assign instr_ready = !q_status.full;
    assign push        = instr_valid && !q_status.full;

    // field extraction
    assign base  = instr.base_value & bts_pkg::ALIGN_MASK;
    assign rn    = instr.instruction[19:16];
    assign p_bit = instr.instruction[bts_pkg::BIT_P];
    assign u_bit = instr.instruction[bts_pkg::BIT_U];
    assign w_bit = instr.instruction[bts_pkg::BIT_W];
    assign list  = instr.instruction[15:0] & bts_pkg::LIST_MASK;

    // block size and addresses
    assign count      = bts_pkg::list_count(list);
    assign span       = {25'd0, count, 2'b00};
    assign up_start   = base + (p_bit ? bts_pkg::WORD_BYTES : 32'd0);
    assign down_start = base - span + (p_bit ? 32'd0 : bts_pkg::WORD_BYTES);
    assign new_base   = u_bit ? (base + span) : (base - span);

    // command build
    always_comb
    begin
        cmd.undef      = (rn == bts_pkg::PC_INDEX) || ({1'b0, rn} >= 5'(bts_pkg::REG_COUNT));
        cmd.base_reg   = rn;
        cmd.reg_list   = list;
        cmd.start_addr = u_bit ? up_start : down_start;
        cmd.new_base   = w_bit ? new_base : 32'd0;
        cmd.is_load    = instr.instruction[bts_pkg::BIT_L];
        cmd.write_back = w_bit;
    end

endmodule

[design/bts_queue.sv]
// short command queue between front and back
module bts_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bts_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output bts_pkg::cmd_t      head_cmd,
    output bts_pkg::q_status_t status
);

    bts_pkg::cmd_t                   mem [bts_pkg::QUEUE_DEPTH];
    logic [bts_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [bts_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [bts_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [bts_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [bts_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [bts_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    assign status.full  = (count_reg == bts_pkg::QUEUE_CNT_W'(bts_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    // pointer advance with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == bts_pkg::QUEUE_PTR_W'(bts_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == bts_pkg::QUEUE_PTR_W'(bts_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

[design/bts_back.sv]
// back end: walks a command's register list and drives result transfers
module bts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bts_pkg::q_status_t q_status,
    input  bts_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output bts_pkg::result_t   result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    bts_pkg::cmd_t    cmd_reg;
    bts_pkg::cmd_t    cmd_next;
    logic [15:0]      list_reg;
    logic [15:0]      list_next;
    logic [31:0]      addr_reg;
    logic [31:0]      addr_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    bts_pkg::result_t out_reg;
    bts_pkg::result_t out_next;
    logic             can_emit;
    logic [3:0]       low_index;

    assign can_emit     = !out_valid_reg || result_ready;
    assign pop          = (state_reg == ST_IDLE) && !q_status.empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // lowest set register in the remaining list
    always_comb
    begin
        low_index = '0;
        for (int i = 15; i >= 0; i--)
        begin
            if (list_reg[i])
                low_index = 4'(i);
        end
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        list_next      = list_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    cmd_next   = head_cmd;
                    list_next  = head_cmd.reg_list;
                    addr_next  = head_cmd.start_addr;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    priority if (cmd_reg.undef)
                    begin
                        out_next.kind       = bts_pkg::KIND_UNDEF;
                        out_next.reg_index  = cmd_reg.base_reg;
                        out_next.address    = 32'd0;
                        out_next.is_load    = 1'b0;
                        out_next.write_back = 1'b0;
                        out_next.last       = 1'b1;
                        state_next          = ST_IDLE;
                    end
                    else if (list_reg != 16'd0)
                    begin
                        out_next.kind       = bts_pkg::KIND_XFER;
                        out_next.reg_index  = low_index;
                        out_next.address    = addr_reg;
                        out_next.is_load    = cmd_reg.is_load;
                        out_next.write_back = 1'b0;
                        out_next.last       = 1'b0;
                        list_next           = list_reg & (list_reg - 16'd1);
                        addr_next           = addr_reg + bts_pkg::WORD_BYTES;
                    end
                    else
                    begin
                        out_next.kind       = bts_pkg::KIND_DONE;
                        out_next.reg_index  = cmd_reg.base_reg;
                        out_next.address    = cmd_reg.new_base;
                        out_next.is_load    = 1'b0;
                        out_next.write_back = cmd_reg.write_back;
                        out_next.last       = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            list_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            list_reg      <= list_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

[design/block_transfer_sequencer.sv]
// top level of the block transfer sequencer
//
// instr channel: one transfer carries a load/store-multiple instruction word and
// the value of its base register. result channel: one transfer per memory
// access, in ascending register order at ascending word addresses, then one
// completion transfer with the written-back base (last set). a base register
// of r15 gives a single undefined-instruction transfer instead.
// a front end decodes each instruction (register count, start address, new
// base) into a two-entry command queue; the back end pulls one command at a
// time and walks its register list.
// when the back end is idle, an accepted instruction is written into the queue,
// loaded by the back end, and its first result registered. each defined command
// takes a load step, one transfer per register and a completion step; the list
// walk goes at one register per cycle unless the result stalls; no new command
// is taken until done. the front keeps accepting until the queue is full.
// reset clears the queue and the back end; no result is pending afterwards.
// a stalled result holds in the output register and the walk pauses with it.
module block_transfer_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_ready,
    input  bts_pkg::instr_t  instr,
    output logic             result_valid,
    input  logic             result_ready,
    output bts_pkg::result_t result
);

    bts_pkg::q_status_t q_status;
    bts_pkg::cmd_t      push_cmd;
    bts_pkg::cmd_t      head_cmd;
    logic               push;
    logic               pop;

    // decode
    bts_front u_front (
        .instr_valid (instr_valid),
        .instr_ready (instr_ready),
        .instr       (instr),
        .q_status    (q_status),
        .push        (push),
        .cmd         (push_cmd)
    );

    // command queue
    bts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // list walk and result output
    bts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
